// ===== sv/swds_pkg.sv =====
// shared types, constants and helpers of the stepper wave drive sequencer
package swds_pkg;

  localparam int unsigned COMPARE_BITS_DEF = 16;
  localparam int unsigned ACC_BITS_DEF     = 32;

  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned COIL_BITS   = 4;
  localparam int unsigned PHASE_BITS  = 2;

  localparam logic [BYTE_BITS-1:0] ENTER_CODE = 8'd13;
  localparam logic [BYTE_BITS-1:0] DIGIT_BASE = 8'h30;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_BYTE   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_BUTTON = 2'd2
  } action_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [BYTE_BITS-1:0]   byte_value;
  } item_t;

  // step produced by the update logic
  typedef struct packed {
    logic                 hit;
    logic [COIL_BITS-1:0] coil_pattern;
    logic                 moving_forward;
  } step_t;

  function automatic logic [COIL_BITS-1:0] coil_of(input logic [PHASE_BITS-1:0] phase);
    logic [COIL_BITS-1:0] coil;
    unique case (phase)
      2'd0:    coil = 4'b1000;
      2'd1:    coil = 4'b0100;
      2'd2:    coil = 4'b0010;
      default: coil = 4'b0001;
    endcase
    return coil;
  endfunction

endpackage

// ===== sv/swds_in_stage.sv =====
// input register: holds one item until the update logic takes it
module swds_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [swds_pkg::ACTION_BITS-1:0] in_action,
  input  logic [swds_pkg::BYTE_BITS-1:0]   in_byte_value,
  input  logic                            slot_free,
  output logic                            advance,
  output swds_pkg::item_t                 item
);
  import swds_pkg::*;

  logic  full_r;
  item_t item_r;

  // item moves on when the result slot can take whatever it produces
  assign advance  = full_r && slot_free;
  assign in_ready = !full_r || advance;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ready) begin
      full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action     <= in_action;
      item_r.byte_value <= in_byte_value;
    end
  end

endmodule

// ===== sv/swds_core.sv =====
// sequencer state and the single-pass update for one item
module swds_core #(
  parameter int unsigned COMPARE_BITS = swds_pkg::COMPARE_BITS_DEF,
  parameter int unsigned ACC_BITS     = swds_pkg::ACC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  swds_pkg::item_t item,
  output swds_pkg::step_t step
);
  import swds_pkg::*;

  localparam int unsigned WIDE_BITS = (ACC_BITS > COMPARE_BITS) ? ACC_BITS : COMPARE_BITS;

  logic [ACC_BITS-1:0]     acc_r, acc_nxt;
  logic [COMPARE_BITS-1:0] compare_r, compare_nxt;
  logic [COMPARE_BITS-1:0] tick_r, tick_nxt;
  logic                    running_r, running_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic                    reverse_r, reverse_nxt;
  logic [WIDE_BITS-1:0]    acc_less_one;

  // acc-1 taken at the wider width so a short accumulator still wraps to all ones
  assign acc_less_one = WIDE_BITS'(acc_r) - WIDE_BITS'(1);

  always_comb begin
    acc_nxt     = acc_r;
    compare_nxt = compare_r;
    tick_nxt    = tick_r;
    running_nxt = running_r;
    phase_nxt   = phase_r;
    reverse_nxt = reverse_r;
    step        = '0;
    step.coil_pattern   = coil_of(phase_r);
    step.moving_forward = !reverse_r;
    unique case (item.action)
      ACT_BYTE: begin
        if (item.byte_value != ENTER_CODE) begin
          // acc*10 as two shifts, non-digits fold in the same way
          acc_nxt = (acc_r << 3) + (acc_r << 1) + ACC_BITS'(item.byte_value)
                    - ACC_BITS'(DIGIT_BASE);
        end else begin
          compare_nxt = acc_less_one[COMPARE_BITS-1:0];
          tick_nxt    = '0;
          running_nxt = 1'b1;
          acc_nxt     = '0;
        end
      end
      ACT_TICK: begin
        if (running_r) begin
          if (tick_r != compare_r) begin
            tick_nxt = tick_r + COMPARE_BITS'(1);
          end else begin
            tick_nxt  = '0;
            step.hit  = 1'b1;
            phase_nxt = reverse_r ? phase_r - PHASE_BITS'(1) : phase_r + PHASE_BITS'(1);
          end
        end
      end
      ACT_BUTTON: reverse_nxt = !reverse_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      compare_r <= '0;
      tick_r    <= '0;
      running_r <= 1'b0;
      phase_r   <= '0;
      reverse_r <= 1'b0;
    end else if (advance) begin
      acc_r     <= acc_nxt;
      compare_r <= compare_nxt;
      tick_r    <= tick_nxt;
      running_r <= running_nxt;
      phase_r   <= phase_nxt;
      reverse_r <= reverse_nxt;
    end
  end

endmodule

// ===== sv/swds_out_stage.sv =====
// result register toward the receiver
module swds_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  swds_pkg::step_t                step,
  output logic                           slot_free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swds_pkg::COIL_BITS-1:0] out_coil_pattern,
  output logic                           out_moving_forward
);
  import swds_pkg::*;

  logic                 valid_r;
  logic [COIL_BITS-1:0] coil_r;
  logic                 fwd_r;

  assign slot_free          = !valid_r || out_ready;
  assign out_valid          = valid_r;
  assign out_coil_pattern   = coil_r;
  assign out_moving_forward = fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= step.hit;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.hit) begin
      coil_r <= step.coil_pattern;
      fwd_r  <= step.moving_forward;
    end
  end

endmodule

// ===== sv/stepper_wave_drive_sequencer.sv =====
// stepper wave drive sequencer: top level
//
// input channel (in_valid/in_ready) carries events: action 0 is a received
//   serial byte in in_byte_value, action 1 a one millisecond tick, action 2
//   a direction button press; action 3 is ignored
// digits fold into a decimal accumulator, carriage return loads the step
//   period (accumulator minus one), restarts the tick counter and clears
//   the accumulator
// output channel (out_valid/out_ready) carries one coil step every
//   period+1 ticks: a one-hot coil pattern and the direction it moved in
// path: an item is registered on entry, updated in one pass and its step,
//   if any, is written to the result register when the item advances
// throughput: one item per cycle unless a step is stalled, set by the
//   single update pass between the input register and the result register
// stall: while a step waits in the result register and out_ready is low,
//   the input register holds its item and in_ready drops once it is full;
//   items that give no step still wait behind it to keep order
// reset: synchronous active-low rst_n empties both registers, clears the timer
//   (stopped), accumulator, period, phase and direction (forward)
module stepper_wave_drive_sequencer #(
  parameter int unsigned COMPARE_BITS = swds_pkg::COMPARE_BITS_DEF,
  parameter int unsigned ACC_BITS     = swds_pkg::ACC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swds_pkg::ACTION_BITS-1:0] in_action,
  input  logic [swds_pkg::BYTE_BITS-1:0]   in_byte_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [swds_pkg::COIL_BITS-1:0]   out_coil_pattern,
  output logic                             out_moving_forward
);
  import swds_pkg::*;

  logic  advance;
  logic  slot_free;
  item_t item;
  step_t step;

  // input register
  swds_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .slot_free     (slot_free),
    .advance       (advance),
    .item          (item)
  );

  // state and update pass
  swds_core #(
    .COMPARE_BITS (COMPARE_BITS),
    .ACC_BITS     (ACC_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .step    (step)
  );

  // result register
  swds_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .step               (step),
    .slot_free          (slot_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coil_pattern   (out_coil_pattern),
    .out_moving_forward (out_moving_forward)
  );

`ifndef SYNTH
  // a step always drives exactly one coil
  a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_coil_pattern))
    else $error("coil pattern not one-hot");

  // input back-pressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
